// ===== hdl/dfpmdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and constants for the decimal fixed point mul/div/mod core.
// No dependencies; used by every module of the block.
package dfpmdm_pkg;

    // scaling
    localparam int unsigned FRACTION_DIGITS_DEF = 6;

    // op codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_MUL  = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;
    localparam logic [1:0] OP_REM  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]         op;
        logic signed [63:0] operand;
    } in_item_t;

    // result item
    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } out_item_t;

    // handshake between sequencer and a serial unit
    typedef struct packed {
        logic start;
    } serial_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } serial_sts_t;

    // ten to the n, worked out at elaboration
    function automatic logic [63:0] pow10(input int unsigned n);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dfpmdm_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial shift-add multiplier, 64 x 64 -> 128 bits, one multiplier bit per cycle.
// Depends on dfpmdm_pkg for the control structs.
module dfpmdm_mul
    import dfpmdm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire serial_ctl_t  ctl,
    input  wire logic [63:0]  multiplicand,
    input  wire logic [63:0]  multiplier,
    output serial_sts_t       sts,
    output logic [127:0]      product
);

    localparam logic [5:0] LAST_STEP = 6'd63;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [64:0] sum;

    // one partial product per cycle, low product bits shift into the multiplier register
    always_comb
    begin
        sum        = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : 65'd0);
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        if (ctl.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            hi_next    = '0;
            lo_next    = multiplier;
            mcand_next = multiplicand;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[64:1];
            lo_next  = {sum[0], lo_reg[63:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = {hi_reg, lo_reg};

endmodule
`default_nettype wire

// ===== hdl/dfpmdm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Radix-2 restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit per cycle.
// Depends on dfpmdm_pkg for the control structs.
module dfpmdm_div
    import dfpmdm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire serial_ctl_t   ctl,
    input  wire logic [127:0]  dividend,
    input  wire logic [63:0]   divisor,
    output serial_sts_t        sts,
    output logic [127:0]       quotient,
    output logic [63:0]        remainder
);

    localparam logic [6:0] LAST_STEP = 7'd127;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] num_reg, num_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  dsr_reg, dsr_next;
    logic [64:0]  shifted;
    logic [65:0]  diff;
    logic         ge;

    // shift in one dividend bit, trial subtract, quotient bit enters at the bottom
    always_comb
    begin
        shifted  = {rem_reg, num_reg[127]};
        diff     = {1'b0, shifted} - {2'b00, dsr_reg};
        ge       = ~diff[65];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[63:0] : shifted[63:0];
            num_next = {num_reg[126:0], ge};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== hdl/decimal_fixed_point_mul_div_mod_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Signed decimal fixed point accumulator (values scaled by ten to FRACTION_DIGITS) with
// load, multiply, divide and truncated remainder. One item is worked at a time. Load and
// any divide or remainder by zero go through the result registers and S_OUT to the
// output register. Remainder runs 128 steps of the serial divider, then its done pulse
// and S_OUT. Multiply and divide run 64 steps of the bit-serial multiplier (magnitude
// times operand, or times ten to FRACTION_DIGITS for divide), whose done pulse starts
// 128 steps of the divider, then its done pulse, S_ROUND, S_SIGN and S_OUT. The next
// item can be taken in the same cycle the result is shown. The result is held in an
// output register, so a finished item may wait there while the next one is taken.
// Depends on dfpmdm_pkg, dfpmdm_mul and dfpmdm_div.
module decimal_fixed_point_mul_div_mod_core
    import dfpmdm_pkg::*;
#(
    parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    localparam logic [63:0] SCALE = pow10(FRACTION_DIGITS);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  acc_reg, acc_next;
    out_item_t    out_reg, out_next;
    logic [1:0]   op_reg, op_next;
    logic         neg_reg, neg_next;
    logic         a_neg_reg, a_neg_next;
    logic [63:0]  dsr_reg, dsr_next;
    logic [127:0] q_reg, q_next;
    logic         rnd_reg, rnd_next;
    logic [63:0]  res_value_reg, res_value_next;
    logic [1:0]   res_status_reg, res_status_next;

    logic         accept;
    logic         out_free;
    logic [63:0]  ma, mb;
    logic         over;

    serial_ctl_t  mul_ctl, div_ctl;
    serial_sts_t  mul_sts, div_sts;
    logic [63:0]  mul_b;
    logic [127:0] product;
    logic [127:0] div_dividend;
    logic [63:0]  div_divisor;
    logic [127:0] quotient;
    logic [63:0]  remainder;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // magnitudes of accumulator and operand
    assign ma = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign mb = in_item.operand[63] ? (64'd0 - in_item.operand) : in_item.operand;

    // serial unit hookup
    assign mul_ctl.start = accept && ((in_item.op == OP_MUL) || (in_item.op == OP_DIV && mb != 64'd0));
    assign mul_b         = (in_item.op == OP_MUL) ? mb : SCALE;
    assign div_ctl.start = (state_reg == S_MUL && mul_sts.done)
                        || (accept && in_item.op == OP_REM && mb != 64'd0);
    assign div_dividend  = (state_reg == S_IDLE) ? {64'd0, ma} : product;
    assign div_divisor   = (state_reg == S_IDLE) ? mb : dsr_reg;

    dfpmdm_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (mul_ctl),
        .multiplicand (ma),
        .multiplier   (mul_b),
        .sts          (mul_sts),
        .product      (product)
    );

    dfpmdm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .sts       (div_sts),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // overflow of the rounded magnitude against the signed range
    assign over = (q_reg[127:64] != 64'd0)
               || (neg_reg ? (q_reg[63] && (q_reg[62:0] != 63'd0)) : q_reg[63]);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        acc_next        = acc_reg;
        out_next        = out_reg;
        op_next         = op_reg;
        neg_next        = neg_reg;
        a_neg_next      = a_neg_reg;
        dsr_next        = dsr_reg;
        q_next          = q_reg;
        rnd_next        = rnd_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_item.op;
                    neg_next   = acc_reg[63] ^ in_item.operand[63];
                    a_neg_next = acc_reg[63];
                    dsr_next   = (in_item.op == OP_MUL) ? SCALE : mb;
                    case (in_item.op)
                        OP_LOAD:
                        begin
                            res_value_next  = in_item.operand;
                            res_status_next = ST_OK;
                            state_next      = S_OUT;
                        end
                        OP_MUL:
                            state_next = S_MUL;
                        default:
                        begin
                            if (mb == 64'd0)
                            begin
                                res_value_next  = acc_reg;
                                res_status_next = ST_DIV_ZERO;
                                state_next      = S_OUT;
                            end
                            else if (in_item.op == OP_DIV)
                                state_next = S_MUL;
                            else
                                state_next = S_DIV;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                if (mul_sts.done)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    if (op_reg == OP_REM)
                    begin
                        res_value_next  = a_neg_reg ? (64'd0 - remainder) : remainder;
                        res_status_next = ST_OK;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        // remainder is at least half the divisor
                        q_next     = quotient;
                        rnd_next   = {remainder, 1'b0} >= {1'b0, dsr_reg};
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND:
            begin
                q_next     = q_reg + {127'd0, rnd_reg};
                state_next = S_SIGN;
            end
            S_SIGN:
            begin
                res_value_next  = neg_reg ? (64'd0 - q_reg[63:0]) : q_reg[63:0];
                res_status_next = over ? ST_OVERFLOW : ST_OK;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next.value  = res_value_reg;
                    out_next.status = res_status_reg;
                    out_valid_next  = 1'b1;
                    acc_next        = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        op_reg         <= op_next;
        neg_reg        <= neg_next;
        a_neg_reg      <= a_neg_next;
        dsr_reg        <= dsr_next;
        q_reg          <= q_next;
        rnd_reg        <= rnd_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("item taken while another is in flight");

    // multiplier finishes only while the sequencer waits for it
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.done |-> (state_reg == S_MUL))
        else $error("multiplier done outside multiply phase");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide phase");

    // serial units are idle whenever a new item can be taken
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!mul_sts.busy && !div_sts.busy))
        else $error("serial unit busy while waiting for an item");

    // a shown result is the current accumulator
    a_acc_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.value == acc_reg))
        else $error("result value differs from accumulator");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ST_OK || out_reg.status == ST_DIV_ZERO
                           || out_reg.status == ST_OVERFLOW))
        else $error("undefined status code");

endmodule
`default_nettype wire

// ===== tb/sv/tb_decimal_fixed_point_mul_div_mod_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the decimal fixed point mul/div/mod accumulator core.
// Predicts each result with 128-bit arithmetic and checks it as the core returns it.
// Depends on dfpmdm_pkg and decimal_fixed_point_mul_div_mod_core.
module tb_decimal_fixed_point_mul_div_mod_core;
    import dfpmdm_pkg::*;

    localparam int unsigned FRAC_DIGITS = FRACTION_DIGITS_DEF;
    localparam int unsigned RANDOM_ITEMS = 1560;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 250;
    // slowest run is roughly 1600 items
    localparam int unsigned RUN_LIMIT_CYCLES = 2_500_000;

    localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_WHOLE     = 64'd1_000_000;

    typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_mode_t;

    // decimal scale factors for the guard digit
    function automatic logic [127:0] ten_to(input int unsigned n);
        logic [127:0] p;
        p = 128'd1;
        for (int unsigned i = 0; i < n; i++)
            p = p * 128'd10;
        return p;
    endfunction

    localparam logic [127:0] GUARD_DOWN = ten_to(FRAC_DIGITS - 1);
    localparam logic [127:0] GUARD_UP   = ten_to(FRAC_DIGITS + 1);

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    logic [63:0]  accumulator_model;
    out_item_t    pending_results[$];
    out_item_t    oldest_result;
    int unsigned  mismatch_count;
    int unsigned  burst_left;
    int unsigned  hold_request;
    int unsigned  hold_left;
    int unsigned  mode_left;
    ready_mode_t  ready_mode;

    decimal_fixed_point_mul_div_mod_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (RUN_LIMIT_CYCLES) @(posedge clk);
        $display("decimal_fixed_point_mul_div_mod_core verification failed");
        $finish;
    end

    function automatic logic [63:0] magnitude_of(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // drop the guard digit rounding half up, apply the sign, flag overflow
    function automatic logic [1:0] round_guard_digit(input logic [127:0] guarded,
                                                     input logic negative);
        logic [127:0] rounded;
        logic         over;
        rounded = guarded / 128'd10;
        if ((guarded % 128'd10) >= 128'd5)
            rounded = rounded + 128'd1;
        if (negative)
            over = (rounded[127:64] != 64'd0) || (rounded[63:0] > MOST_NEGATIVE);
        else
            over = (rounded[127:64] != 64'd0) || (rounded[63:0] > MOST_POSITIVE);
        accumulator_model = negative ? (64'd0 - rounded[63:0]) : rounded[63:0];
        return over ? ST_OVERFLOW : ST_OK;
    endfunction

    // new accumulator and status for one accepted item
    function automatic out_item_t apply_operation(input in_item_t item);
        out_item_t    result;
        logic [63:0]  acc_mag;
        logic [63:0]  opd_mag;
        logic [63:0]  remainder;
        logic         negative;
        logic [1:0]   status;
        acc_mag  = magnitude_of(accumulator_model);
        opd_mag  = magnitude_of(item.operand);
        negative = accumulator_model[63] ^ item.operand[63];
        status   = ST_OK;
        case (item.op)
            OP_LOAD:
                accumulator_model = item.operand;
            OP_MUL:
                status = round_guard_digit(({64'd0, acc_mag} * {64'd0, opd_mag}) / GUARD_DOWN,
                                           negative);
            OP_DIV:
                if (opd_mag == 64'd0)
                    status = ST_DIV_ZERO;
                else
                    status = round_guard_digit(({64'd0, acc_mag} * GUARD_UP) / {64'd0, opd_mag},
                                               negative);
            OP_REM:
                if (opd_mag == 64'd0)
                    status = ST_DIV_ZERO;
                else
                begin
                    remainder = acc_mag % opd_mag;
                    accumulator_model = accumulator_model[63] ? (64'd0 - remainder) : remainder;
                end
            default:
                ;
        endcase
        result.value  = accumulator_model;
        result.status = status;
        return result;
    endfunction

    // operand drawn from a mix of magnitudes, with occasional extremes
    function automatic logic [63:0] random_fixed_value();
        logic [63:0]  v;
        int unsigned  kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:    v = {$urandom, $urandom};
            2, 3:    v = 64'($urandom_range(0, 2000)) * ONE_WHOLE + 64'($urandom_range(0, 999999));
            4:       v = 64'($urandom_range(0, 200));
            5:       v = 64'($urandom_range(0, 999)) * ONE_WHOLE;
            6:       v = {32'd0, $urandom};
            7:       v = 64'($urandom_range(0, 20)) * 64'd500_000;
            8:
                case ($urandom_range(0, 4))
                    0:       v = MOST_POSITIVE;
                    1:       v = MOST_NEGATIVE;
                    2:       v = 64'd0;
                    3:       v = 64'd1;
                    default: v = ONE_WHOLE;
                endcase
            default: v = 64'($urandom) << $urandom_range(0, 31);
        endcase
        if (kind != 8 && $urandom_range(0, 1) == 1)
            v = 64'd0 - v;
        return v;
    endfunction

    // offer one item, record its prediction once taken, then maybe pause
    task automatic send_item(input logic [1:0] op, input logic [63:0] operand);
        in_item_t     item;
        int unsigned  gap;
        item.op      = op;
        item.operand = operand;
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_operation(item));
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver ready pattern, with an optional long hold-off
    initial
    begin
        out_ready    <= 1'b0;
        hold_request = 0;
        hold_left    = 0;
        mode_left    = 0;
        ready_mode   = READY_ALWAYS;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 120);
            end
            else
                mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (ready_mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                    default:      out_ready <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    // compare each returned item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value %0d status %0d", $time,
                         out_item.value, out_item.status);
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_item.value !== oldest_result.value)
                begin
                    $display("%0t: value expected %0d actual %0d", $time,
                             oldest_result.value, out_item.value);
                    mismatch_count++;
                end
                if (out_item.status !== oldest_result.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             oldest_result.status, out_item.status);
                    mismatch_count++;
                end
            end
        end
    end

    // extremes, rounding, zero divisors and the most negative value
    task automatic test_directed_corners();
        send_item(OP_MUL,  64'd5_000_000);
        send_item(OP_LOAD, MOST_POSITIVE);
        send_item(OP_MUL,  MOST_POSITIVE);
        send_item(OP_LOAD, MOST_NEGATIVE);
        send_item(OP_MUL,  ONE_WHOLE);
        send_item(OP_MUL,  64'd0 - ONE_WHOLE);
        send_item(OP_LOAD, 64'd1);
        send_item(OP_MUL,  64'd500_000);
        send_item(OP_LOAD, 64'd1);
        send_item(OP_MUL,  64'd499_999);
        send_item(OP_LOAD, 64'd0 - 64'd1);
        send_item(OP_MUL,  64'd500_000);
        send_item(OP_LOAD, 64'd1);
        send_item(OP_DIV,  64'd2_000_000);
        send_item(OP_LOAD, MOST_POSITIVE);
        send_item(OP_DIV,  64'd1);
        send_item(OP_LOAD, 64'd5_000_000);
        send_item(OP_DIV,  64'd0);
        send_item(OP_REM,  64'd0);
        send_item(OP_LOAD, 64'd0 - 64'd7_500_000);
        send_item(OP_REM,  64'd2_000_000);
        send_item(OP_LOAD, MOST_NEGATIVE);
        send_item(OP_REM,  MOST_NEGATIVE);
        send_item(OP_LOAD, 64'd3_000_000);
        send_item(OP_DIV,  MOST_NEGATIVE);
        send_item(OP_LOAD, MOST_NEGATIVE);
        send_item(OP_DIV,  64'd0 - ONE_WHOLE);
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_output_hold_off();
        hold_request = HOLD_OFF_CYCLES;
        send_item(OP_LOAD, 64'd12_500_000);
        for (int i = 0; i < 7; i++)
            send_item(2'($urandom_range(OP_MUL, OP_REM)), random_fixed_value());
    endtask

    // load then a short chain of operations, with some stray items mixed in
    task automatic test_random_sequences(input int unsigned budget);
        int unsigned sent;
        int unsigned chain;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(2'($urandom_range(OP_LOAD, OP_REM)), {$urandom, $urandom});
                sent++;
            end
            else
            begin
                send_item(OP_LOAD, random_fixed_value());
                sent++;
                chain = $urandom_range(1, 6);
                for (int unsigned k = 0; k < chain; k++)
                begin
                    send_item(2'($urandom_range(OP_MUL, OP_REM)), random_fixed_value());
                    sent++;
                end
            end
        end
    endtask

    // reset, tests in turn, drain and verdict
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_item        <= '0;
        mismatch_count = 0;
        burst_left     = 0;
        accumulator_model = 64'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_output_hold_off();
        test_random_sequences(RANDOM_ITEMS);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("decimal_fixed_point_mul_div_mod_core verification clean");
        else
            $display("decimal_fixed_point_mul_div_mod_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dfpmdm_pkg.sv
hdl/dfpmdm_mul.sv
hdl/dfpmdm_div.sv
hdl/decimal_fixed_point_mul_div_mod_core.sv
tb/sv/tb_decimal_fixed_point_mul_div_mod_core.sv
